[sv/ftun_pkg.sv]
// Package: shared widths and state codes for the fan triangulator.
package ftun_pkg;

    localparam int COORD_BITS_DEF = 20;
    localparam int NORM_BITS      = 16;
    localparam int NORM_ONE       = 16384;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SHRINK,
        ST_MUL,
        ST_CHECK,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } ftun_state_t;

endpackage

[sv/ftun_if.sv]
// Interface: valid/ready channel carrying one word of type word_t.
interface ftun_if #(parameter type word_t = logic) ();
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/fan_triangulate_with_unit_normal_top.sv]
// Top level: fan triangle splitter with a unit face normal per triangle.
//
//  channel | dir | payload
//  vin     | in  | vertex_x, vertex_y, vertex_z (signed), starts_face
//  tri     | out | normal_x/y/z (Q1.14), corner_a/b/c_x/y/z
//
// First and second vertex of a face give no word.
// A triangle passes a shrink step (repeated at wider coordinates), six products on one
// 32x32 multiplier, a check, normalization, the squares, the square root (one bit a
// cycle) and three divisions (one quotient bit a cycle). A zero normal goes from the
// check straight to the output.
// The result sits in an output register; a vertex that makes no triangle is taken
// while it waits, one that makes a triangle stalls until the word leaves. Reset
// clears the face state and the control.
module fan_triangulate_with_unit_normal_top
    import ftun_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  logic clk,
    input  logic rst_n,
    ftun_if.sink   vin,
    ftun_if.source tri_out
);
    localparam int DB = COORD_BITS + 1;

    typedef logic signed [COORD_BITS-1:0] crd_t;

    ftun_state_t state_reg, state_next;

    crd_t anc_reg [3];
    crd_t prv_reg [3];
    crd_t cur_reg [3];
    crd_t bv_reg [3];
    logic [1:0] seen_reg;

    logic signed [DB-1:0] du_reg [3];
    logic signed [DB-1:0] dv_reg [3];
    logic signed [31:0] su_reg [3];
    logic signed [31:0] sv_reg [3];
    logic signed [63:0] prod_reg;
    logic signed [64:0] n_reg [3];
    logic [63:0] m_reg [3];
    logic [63:0] sum_reg;
    logic [63:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  sq_cnt_reg;
    logic [3:0]  mul_cnt_reg;
    logic [1:0]  comp_reg;
    logic [5:0]  div_cnt_reg;
    logic [45:0] dnum_reg;
    logic [47:0] drem_reg;
    logic [16:0] quo_reg;

    logic signed [NORM_BITS-1:0] qn_reg [3];
    logic signed [NORM_BITS-1:0] nout_reg [3];
    crd_t oa_reg [3];
    crd_t ob_reg [3];
    crd_t oc_reg [3];
    logic ovalid_reg;

    crd_t in_c [3];
    assign in_c[0] = vin.data.vertex_x;
    assign in_c[1] = vin.data.vertex_y;
    assign in_c[2] = vin.data.vertex_z;

    logic in_take;
    assign vin.ready = (state_reg == ST_IDLE) && !(ovalid_reg && seen_reg == 2'd2
                       && !vin.data.starts_face);
    assign in_take = vin.valid && vin.ready;
    logic make_tri;
    assign make_tri = !vin.data.starts_face && seen_reg == 2'd2;

    // shrink: any magnitude at or above 2^31 forces one right shift
    function automatic logic big31(input logic signed [DB-1:0] w);
        logic [DB:0] m;
        m = w[DB-1] ? -{w[DB-1], w} : {1'b0, w};
        return (DB > 32) ? ((m >> 31) != '0) : 1'b0;
    endfunction

    function automatic logic signed [DB-1:0] shr1(input logic signed [DB-1:0] w);
        logic [DB:0] m;
        m = w[DB-1] ? -{w[DB-1], w} : {1'b0, w};
        m = m >> 1;
        return w[DB-1] ? DB'(-m) : DB'(m);
    endfunction

    function automatic logic signed [31:0] to32(input logic signed [DB-1:0] w);
        return 32'(w);
    endfunction

    // multiplier operand select: products in order u1v2,u2v1,u2v0,u0v2,u0v1,u1v0
    logic signed [31:0] ma, mb;
    always_comb
    begin
        unique case (mul_cnt_reg[3:1])
            3'd0: begin ma = su_reg[1]; mb = sv_reg[2]; end
            3'd1: begin ma = su_reg[2]; mb = sv_reg[1]; end
            3'd2: begin ma = su_reg[2]; mb = sv_reg[0]; end
            3'd3: begin ma = su_reg[0]; mb = sv_reg[2]; end
            3'd4: begin ma = su_reg[0]; mb = sv_reg[1]; end
            default: begin ma = su_reg[1]; mb = sv_reg[0]; end
        endcase
    end

    logic [63:0] top_c;
    always_comb
    begin
        top_c = m_reg[0];
        if (m_reg[1] > top_c) top_c = m_reg[1];
        if (m_reg[2] > top_c) top_c = m_reg[2];
    end

    logic [63:0] bitv_c;
    assign bitv_c  = 64'd1 << {sq_cnt_reg, 1'b0};
    logic [63:0] rt_c;
    assign rt_c = ({32'd0, root_reg} << (sq_cnt_reg + 5'd1)) | bitv_c;

    logic [47:0] dsub_c;
    logic [47:0] dsh_c;
    assign dsh_c  = {drem_reg[46:0], dnum_reg[45]};
    assign dsub_c = dsh_c - {15'd0, root_reg, 1'b0};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_take && make_tri) state_next = ST_SHRINK;
            ST_SHRINK: if (!(big31(du_reg[0]) || big31(du_reg[1]) || big31(du_reg[2]) ||
                             big31(dv_reg[0]) || big31(dv_reg[1]) || big31(dv_reg[2])))
                           state_next = ST_MUL;
            ST_MUL:    if (mul_cnt_reg == 4'd11) state_next = ST_CHECK;
            ST_CHECK:  state_next = (n_reg[0] == '0 && n_reg[1] == '0 && n_reg[2] == '0)
                                    ? ST_OUT : ST_NORM;
            ST_NORM:   if (top_c < (64'd1 << 30) && top_c >= (64'd1 << 29))
                           state_next = ST_SQ;
            ST_SQ:     if (mul_cnt_reg == 4'd5) state_next = ST_SQRT;
            ST_SQRT:   if (sq_cnt_reg == 5'd0) state_next = ST_DIV;
            ST_DIV:    if (div_cnt_reg == 6'd45 && comp_reg == 2'd2) state_next = ST_OUT;
            ST_OUT:    if (!ovalid_reg || tri_out.ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            seen_reg   <= 2'd0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                anc_reg[i] <= '0;
                prv_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && state_next == ST_IDLE)
                ovalid_reg <= 1'b1;
            else if (tri_out.valid && tri_out.ready)
                ovalid_reg <= 1'b0;
            if (in_take)
            begin
                if (vin.data.starts_face || seen_reg == 2'd0)
                begin
                    anc_reg  <= in_c;
                    prv_reg  <= in_c;
                    seen_reg <= 2'd1;
                end
                else
                begin
                    prv_reg  <= in_c;
                    seen_reg <= 2'd2;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                mul_cnt_reg <= '0;
                if (in_take && make_tri)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        du_reg[i]  <= DB'(anc_reg[i]) - DB'(prv_reg[i]);
                        dv_reg[i]  <= DB'(prv_reg[i]) - DB'(in_c[i]);
                        cur_reg[i] <= in_c[i];
                        bv_reg[i]  <= prv_reg[i];
                    end
                end
            end
            ST_SHRINK:
            begin
                if (big31(du_reg[0]) || big31(du_reg[1]) || big31(du_reg[2]))
                    for (int i = 0; i < 3; i++) du_reg[i] <= shr1(du_reg[i]);
                if (big31(dv_reg[0]) || big31(dv_reg[1]) || big31(dv_reg[2]))
                    for (int i = 0; i < 3; i++) dv_reg[i] <= shr1(dv_reg[i]);
                for (int i = 0; i < 3; i++)
                begin
                    su_reg[i] <= to32(du_reg[i]);
                    sv_reg[i] <= to32(dv_reg[i]);
                end
            end
            ST_MUL:
            begin
                mul_cnt_reg <= mul_cnt_reg + 4'd1;
                if (!mul_cnt_reg[0])
                    prod_reg <= ma * mb;
                else
                begin
                    // odd cycle: first product of a pair is held, second subtracts
                    unique case (mul_cnt_reg[3:1])
                        3'd0, 3'd2, 3'd4: n_reg[mul_cnt_reg[3:2]] <= 65'(prod_reg);
                        default: n_reg[mul_cnt_reg[3:2]] <=
                            n_reg[mul_cnt_reg[3:2]] - 65'(prod_reg);
                    endcase
                end
            end
            ST_CHECK:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m_reg[i]  <= n_reg[i][64] ? 64'(-n_reg[i]) : 64'(n_reg[i]);
                    qn_reg[i] <= '0;
                end
            end
            ST_NORM:
            begin
                mul_cnt_reg <= '0;
                sum_reg     <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    if (top_c >= (64'd1 << 30)) m_reg[i] <= m_reg[i] >> 1;
                    else if (top_c < (64'd1 << 29)) m_reg[i] <= m_reg[i] << 1;
                end
            end
            ST_SQ:
            begin
                // each square is a multiply step, then an accumulate step
                mul_cnt_reg <= mul_cnt_reg + 4'd1;
                if (!mul_cnt_reg[0])
                    prod_reg <= $signed({2'b0, m_reg[mul_cnt_reg[2:1]][29:0]}) *
                                $signed({2'b0, m_reg[mul_cnt_reg[2:1]][29:0]});
                else
                    sum_reg <= sum_reg + 64'(prod_reg);
                rem_reg    <= sum_reg + 64'(prod_reg);
                root_reg   <= '0;
                sq_cnt_reg <= 5'd31;
            end
            ST_SQRT:
            begin
                // restoring square root, one root bit per cycle
                if (rem_reg >= rt_c)
                begin
                    rem_reg  <= rem_reg - rt_c;
                    root_reg <= root_reg | (32'd1 << sq_cnt_reg);
                end
                sq_cnt_reg  <= sq_cnt_reg - 5'd1;
                div_cnt_reg <= '0;
                comp_reg    <= '0;
                drem_reg    <= '0;
                quo_reg     <= '0;
                dnum_reg    <= {m_reg[0][30:0], 15'd0} + 46'(root_reg | ((rem_reg >= rt_c)
                               ? (32'd1 << sq_cnt_reg) : 32'd0));
            end
            ST_DIV:
            begin
                // numerator 2*m*16384 + L, divisor 2L, one quotient bit a cycle
                if (div_cnt_reg == 6'd45)
                begin
                    qn_reg[comp_reg] <= n_reg[comp_reg][64]
                        ? NORM_BITS'(-{quo_reg[15:0], ~dsub_c[47]})
                        : NORM_BITS'({quo_reg[15:0], ~dsub_c[47]});
                    div_cnt_reg <= '0;
                    drem_reg    <= '0;
                    quo_reg     <= '0;
                    comp_reg    <= comp_reg + 2'd1;
                    dnum_reg    <= {m_reg[(comp_reg == 2'd0) ? 2'd1 : 2'd2][30:0], 15'd0}
                                   + 46'(root_reg);
                end
                else
                begin
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    dnum_reg    <= {dnum_reg[44:0], 1'b0};
                    if (!dsub_c[47])
                    begin
                        drem_reg <= dsub_c;
                        quo_reg  <= {quo_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dsh_c;
                        quo_reg  <= {quo_reg[15:0], 1'b0};
                    end
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg || tri_out.ready)
                begin
                    nout_reg <= qn_reg;
                    oa_reg   <= anc_reg;
                    ob_reg   <= bv_reg;
                    oc_reg   <= cur_reg;
                end
            end
            default: ;
        endcase
    end

    assign tri_out.valid            = ovalid_reg;
    assign tri_out.data.normal_x    = nout_reg[0];
    assign tri_out.data.normal_y    = nout_reg[1];
    assign tri_out.data.normal_z    = nout_reg[2];
    assign tri_out.data.corner_a_x  = oa_reg[0];
    assign tri_out.data.corner_a_y  = oa_reg[1];
    assign tri_out.data.corner_a_z  = oa_reg[2];
    assign tri_out.data.corner_b_x  = ob_reg[0];
    assign tri_out.data.corner_b_y  = ob_reg[1];
    assign tri_out.data.corner_b_z  = ob_reg[2];
    assign tri_out.data.corner_c_x  = oc_reg[0];
    assign tri_out.data.corner_c_y  = oc_reg[1];
    assign tri_out.data.corner_c_z  = oc_reg[2];

    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !vin.ready) else $error("input taken while busy");
    a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg != 2'd3) else $error("vertex count out of range");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        tri_out.valid && !tri_out.ready |=> $stable(nout_reg[0]))
        else $error("result changed while stalled");

endmodule
